// File: rtl/rart_pkg.sv
package rart_pkg;

    // Fixed field widths of the request and response beats.
    localparam int unsigned INDEX_BITS  = 10;
    localparam int unsigned AMOUNT_BITS = 32;
    localparam int unsigned RESULT_BITS = 48;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                        opcode;
        logic [INDEX_BITS-1:0]          range_low;
        logic [INDEX_BITS-1:0]          range_high;
        logic signed [AMOUNT_BITS-1:0]  add_amount;
    } t_req;

    typedef struct packed {
        logic signed [RESULT_BITS-1:0]  range_maximum;
        logic                           range_empty;
    } t_rsp;

endpackage

// File: rtl/rart_chan.sv
interface rart_chan #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/rart_ram.sv
module rart_ram #(
    parameter int unsigned DW = 48,
    parameter int unsigned AW = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/range_add_range_max_tree.sv
// Range add / range maximum over ELEMENTS signed values, all zero after reset.
// A request beat with opcode OP_ADD adds add_amount to every element of the
// inclusive range [range_low, range_high] and gives no response; a beat with
// OP_QUERY gives one response beat with the maximum over the range, or
// range_empty set (and range_maximum zero) when the range holds no element.
// Indices at or above ELEMENTS are ignored, and every stored sum saturates at
// the signed VALUE_BITS bounds. The values live in a lazy max tree held in two
// single-read, single-write memories (node maxima and pending adds) of
// 2**(clog2(ELEMENTS)+1) entries. After reset the block sweeps both memories
// to zero, one entry per cycle, before it takes its first request beat. One
// request is worked at a time: the sequencer walks the tree depth first. Each
// node visit steps through read, push pending and classify (S_RD, S_PD,
// S_CLS), through S_C0 to S_C2 as well when a pending add is pushed to the
// children or a covered node hands a new add down, and through S_UP once per
// step back up. A typical operation visits about 2*clog2(ELEMENTS) to
// 4*clog2(ELEMENTS) nodes. An empty or reversed add leaves the block idle;
// an empty or reversed query goes straight to S_DONE, with no tree walk. A
// finished response waits in an output register, so the next request is
// taken while it is still held.
module range_add_range_max_tree #(
    parameter int unsigned ELEMENTS   = 1024,
    parameter int unsigned VALUE_BITS = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rart_chan.sink   i_req,
    rart_chan.source o_rsp
);

    // Tree geometry: D levels of interior nodes, heap indices below 2**(D+1).
    localparam int unsigned D  = $clog2(ELEMENTS);
    localparam int unsigned AW = D + 1;
    localparam int unsigned LW = $clog2(D + 1);
    localparam int unsigned SW = (D > 1) ? $clog2(D) : 1;
    localparam int unsigned CW = ((D > rart_pkg::INDEX_BITS) ? D : rart_pkg::INDEX_BITS) + 1;
    localparam int unsigned VW = VALUE_BITS;

    localparam logic [D-1:0]  LAST_INDEX = D'(ELEMENTS - 1);
    localparam logic [CW-1:0] ELEM_CW    = CW'(ELEMENTS);
    localparam logic signed [64:0] VMAX65 = (65'sd1 <<< (VW - 1)) - 65'sd1;
    localparam logic signed [64:0] VMIN65 = -VMAX65 - 65'sd1;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_RD    = 10'b00_0000_0100,
        S_PD    = 10'b00_0000_1000,
        S_C0    = 10'b00_0001_0000,
        S_C1    = 10'b00_0010_0000,
        S_C2    = 10'b00_0100_0000,
        S_CLS   = 10'b00_1000_0000,
        S_UP    = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    // Saturating add of two stored values.
    function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] sum;
        sum = {a[VW-1], a} + {b[VW-1], b};
        if (sum[VW] != sum[VW-1]) begin
            return sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end
        return sum[VW-1:0];
    endfunction

    function automatic logic [D-1:0] mid_of(input logic [D-1:0] lo, input logic [D-1:0] hi);
        logic [D:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        return sum[D:1];
    endfunction

    function automatic logic [VW-1:0] vmax(input logic [VW-1:0] a, input logic [VW-1:0] b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

    t_state                r_state, n_state;
    rart_pkg::t_opcode     r_op, n_op;
    logic [CW-1:0]         r_ql, n_ql, r_qr, n_qr;
    logic [VW-1:0]         r_amt, n_amt;
    logic [AW-1:0]         r_node, n_node;
    logic [D-1:0]          r_lo, n_lo, r_hi, n_hi;
    logic [LW-1:0]         r_lvl, n_lvl;
    logic [VW-1:0]         r_m, n_m, r_p, n_p, r_ret, n_ret, r_best, n_best;
    logic                  r_full, n_full, r_found, n_found;
    logic [AW-1:0]         r_clr, n_clr;
    logic                  r_ovalid, n_ovalid;
    rart_pkg::t_rsp        r_rsp, n_rsp;

    // Stack of interior nodes on the current path.
    logic [D-1:0]          stk_lo   [D];
    logic [D-1:0]          stk_hi   [D];
    logic [VW-1:0]         stk_lmax [D];
    logic                  stk_we, lmax_we;
    logic [SW-1:0]         push_idx, top_idx;
    logic [LW-1:0]         lvl_dec;

    // Memory ports.
    logic                  max_we, pnd_we;
    logic [AW-1:0]         max_waddr, pnd_waddr, max_raddr, pnd_raddr;
    logic [VW-1:0]         max_wdata, pnd_wdata, max_q, pnd_q;

    logic [AW-1:0]         left_node, right_node;
    logic [CW-1:0]         lo_cw, hi_cw;
    logic                  is_out, is_full, is_leaf;
    logic [D-1:0]          pmid;
    logic [VW-1:0]         sat_mp, sat_ma, up_max;
    logic signed [64:0]    amt65;
    logic [63:0]           best64;
    logic [CW-1:0]         req_ql, req_qr;

    rart_ram #(.DW(VW), .AW(AW)) u_max_ram (
        .i_clk   (i_clk),
        .i_we    (max_we),
        .i_waddr (max_waddr),
        .i_wdata (max_wdata),
        .i_raddr (max_raddr),
        .o_rdata (max_q)
    );

    rart_ram #(.DW(VW), .AW(AW)) u_pnd_ram (
        .i_clk   (i_clk),
        .i_we    (pnd_we),
        .i_waddr (pnd_waddr),
        .i_wdata (pnd_wdata),
        .i_raddr (pnd_raddr),
        .o_rdata (pnd_q)
    );

    assign left_node  = {r_node[AW-2:0], 1'b0};
    assign right_node = {r_node[AW-2:0], 1'b1};
    assign lo_cw      = CW'(r_lo);
    assign hi_cw      = CW'(r_hi);
    assign is_out     = (lo_cw > r_qr) || (hi_cw < r_ql);
    assign is_full    = (lo_cw >= r_ql) && (hi_cw <= r_qr);
    assign is_leaf    = (r_lo == r_hi);
    assign push_idx   = r_lvl[SW-1:0];
    assign lvl_dec    = r_lvl - LW'(1);
    assign top_idx    = lvl_dec[SW-1:0];
    assign pmid       = mid_of(stk_lo[top_idx], stk_hi[top_idx]);
    assign sat_mp     = sat_add(max_q, pnd_q);
    assign sat_ma     = sat_add(r_m, r_amt);
    assign up_max     = vmax(stk_lmax[top_idx], r_ret);
    assign req_ql     = CW'(i_req.data.range_low);
    assign req_qr     = CW'(i_req.data.range_high);
    assign best64     = 64'($signed(r_best));

    // The amount is brought into the stored value range once, at acceptance.
    always_comb begin
        amt65 = {{33{i_req.data.add_amount[31]}}, i_req.data.add_amount};
        if (amt65 > VMAX65) begin
            amt65 = VMAX65;
        end else if (amt65 < VMIN65) begin
            amt65 = VMIN65;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_ql     = r_ql;
        n_qr     = r_qr;
        n_amt    = r_amt;
        n_node   = r_node;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_lvl    = r_lvl;
        n_m      = r_m;
        n_p      = r_p;
        n_ret    = r_ret;
        n_best   = r_best;
        n_full   = r_full;
        n_found  = r_found;
        n_clr    = r_clr;
        n_ovalid = r_ovalid;
        n_rsp    = r_rsp;

        max_we    = 1'b0;
        max_waddr = r_node;
        max_wdata = sat_mp;
        max_raddr = r_node;
        pnd_we    = 1'b0;
        pnd_waddr = r_node;
        pnd_wdata = '0;
        pnd_raddr = r_node;
        stk_we    = 1'b0;
        lmax_we   = 1'b0;

        if (o_rsp.valid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                max_we    = 1'b1;
                max_waddr = r_clr;
                max_wdata = '0;
                pnd_we    = 1'b1;
                pnd_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.data.opcode;
                    n_ql    = req_ql;
                    n_qr    = req_qr;
                    n_amt   = VW'(amt65);
                    n_node  = AW'(1);
                    n_lo    = '0;
                    n_hi    = LAST_INDEX;
                    n_lvl   = '0;
                    n_best  = '0;
                    n_found = 1'b0;
                    if ((req_ql <= req_qr) && (req_ql < ELEM_CW)) begin
                        n_state = S_RD;
                    end else if (i_req.data.opcode == rart_pkg::OP_QUERY) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RD: begin
                n_state = S_PD;
            end
            S_PD: begin
                if (pnd_q != '0) begin
                    max_we  = 1'b1;
                    pnd_we  = 1'b1;
                    n_m     = sat_mp;
                    n_p     = pnd_q;
                    n_full  = 1'b0;
                    n_state = is_leaf ? S_CLS : S_C0;
                end else begin
                    n_m     = max_q;
                    n_state = S_CLS;
                end
            end
            S_C0: begin
                pnd_raddr = left_node;
                n_state   = S_C1;
            end
            S_C1: begin
                pnd_we    = 1'b1;
                pnd_waddr = left_node;
                pnd_wdata = sat_add(pnd_q, r_p);
                pnd_raddr = right_node;
                n_state   = S_C2;
            end
            S_C2: begin
                pnd_we    = 1'b1;
                pnd_waddr = right_node;
                pnd_wdata = sat_add(pnd_q, r_p);
                n_state   = r_full ? S_UP : S_CLS;
            end
            S_CLS: begin
                if (is_out) begin
                    n_ret   = r_m;
                    n_state = S_UP;
                end else if (is_full) begin
                    if (r_op == rart_pkg::OP_QUERY) begin
                        n_best  = r_found ? vmax(r_best, r_m) : r_m;
                        n_found = 1'b1;
                        n_state = S_UP;
                    end else if (r_amt == '0) begin
                        n_ret   = r_m;
                        n_state = S_UP;
                    end else begin
                        // Covered node: apply the add and push it at once.
                        max_we    = 1'b1;
                        max_wdata = sat_ma;
                        n_m       = sat_ma;
                        n_ret     = sat_ma;
                        n_p       = r_amt;
                        n_full    = 1'b1;
                        n_state   = is_leaf ? S_UP : S_C0;
                    end
                end else begin
                    stk_we  = 1'b1;
                    n_lvl   = r_lvl + LW'(1);
                    n_node  = left_node;
                    n_hi    = mid_of(r_lo, r_hi);
                    n_state = S_RD;
                end
            end
            S_UP: begin
                if (r_lvl == '0) begin
                    n_state = (r_op == rart_pkg::OP_QUERY) ? S_DONE : S_IDLE;
                end else if (!r_node[0]) begin
                    // Left subtree finished: keep its maximum, visit the right one.
                    lmax_we = 1'b1;
                    n_node  = r_node + AW'(1);
                    n_lo    = pmid + D'(1);
                    n_hi    = stk_hi[top_idx];
                    n_state = S_RD;
                end else begin
                    n_node = r_node >> 1;
                    n_lo   = stk_lo[top_idx];
                    n_hi   = stk_hi[top_idx];
                    n_lvl  = lvl_dec;
                    if (r_op == rart_pkg::OP_ADD) begin
                        max_we    = 1'b1;
                        max_waddr = r_node >> 1;
                        max_wdata = up_max;
                        n_ret     = up_max;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid                = 1'b1;
                    n_rsp.range_maximum     = r_found ? best64[rart_pkg::RESULT_BITS-1:0] : '0;
                    n_rsp.range_empty       = !r_found;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_lvl    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_lvl    <= n_lvl;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_ql    <= n_ql;
        r_qr    <= n_qr;
        r_amt   <= n_amt;
        r_node  <= n_node;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_m     <= n_m;
        r_p     <= n_p;
        r_ret   <= n_ret;
        r_best  <= n_best;
        r_full  <= n_full;
        r_found <= n_found;
        r_rsp   <= n_rsp;
        if (stk_we) begin
            stk_lo[push_idx] <= r_lo;
            stk_hi[push_idx] <= r_hi;
        end
        if (lmax_we) begin
            stk_lmax[top_idx] <= r_ret;
        end
    end

    // The path stack never grows past the tree depth.
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl <= LW'(D))
        else $error("tree walk deeper than the tree");

    // Back at the top of the stack the walk must be at the root.
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP && r_lvl == '0) |-> (r_node == AW'(1)))
        else $error("walk ended away from the root");

    // Only a query produces a response beat.
    a_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_op == rart_pkg::OP_QUERY))
        else $error("response for an add");

    // An empty response always carries a zero maximum.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_rsp.range_empty) |-> (r_rsp.range_maximum == '0))
        else $error("empty response with a nonzero maximum");

endmodule

// File: bench/tb_range_add_range_max_tree.sv
module tb_range_add_range_max_tree;

    // Elements held by the block at its default size.
    localparam int unsigned N_ELEM      = 1024;
    localparam int unsigned N_RANDOM    = 1130;
    // The last stretch of random beats runs with no idling on either side.
    localparam int unsigned QUIET_AFTER = 980;
    localparam longint      SUM_MAX     = 64'sd140737488355327;
    localparam longint      SUM_MIN     = -64'sd140737488355328;

    logic i_clk;
    logic i_rst_n;

    rart_chan #(.T(rart_pkg::t_req)) req_if ();
    rart_chan #(.T(rart_pkg::t_rsp)) rsp_if ();

    range_add_range_max_tree dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // One row of the directed part. Where has_exp is set the response is
    // typed in; otherwise the tree model below supplies it.
    typedef struct {
        rart_pkg::t_opcode op;
        int unsigned       lo;
        int unsigned       hi;
        int                amt;
        bit                has_exp;
        longint            exp_max;
        bit                exp_empty;
    } t_dir_row;

    // Own copy of the lazy max tree: node maxima and pending adds.
    longint tree_max_q [2*N_ELEM];
    longint tree_pend_q[2*N_ELEM];

    rart_pkg::t_rsp pending_rsp_q[$];
    int     err_count;
    bit     quiet;
    bit     stim_done;

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    // The one reset of the run.
    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    function automatic longint sat_sum(input longint a, input longint b);
        if (b > 0 && a > SUM_MAX - b) return SUM_MAX;
        if (b < 0 && a < SUM_MIN - b) return SUM_MIN;
        return a + b;
    endfunction

    // Applies a node's pending add to its own maximum and hands it down.
    function automatic void settle_node(input int node, input int lo, input int hi);
        longint p;
        p = tree_pend_q[node];
        if (p == 0) return;
        tree_max_q[node] = sat_sum(tree_max_q[node], p);
        if (lo != hi) begin
            tree_pend_q[2*node]   = sat_sum(tree_pend_q[2*node], p);
            tree_pend_q[2*node+1] = sat_sum(tree_pend_q[2*node+1], p);
        end
        tree_pend_q[node] = 0;
    endfunction

    function automatic void tree_add(input int node, input int lo, input int hi,
                                     input int ql, input int qr, input longint v);
        int mid;
        settle_node(node, lo, hi);
        if (lo > qr || hi < ql) return;
        if (lo >= ql && hi <= qr) begin
            tree_pend_q[node] = sat_sum(tree_pend_q[node], v);
            settle_node(node, lo, hi);
            return;
        end
        mid = (lo + hi) >> 1;
        tree_add(2*node, lo, mid, ql, qr, v);
        tree_add(2*node+1, mid + 1, hi, ql, qr, v);
        tree_max_q[node] = (tree_max_q[2*node] > tree_max_q[2*node+1]) ?
                           tree_max_q[2*node] : tree_max_q[2*node+1];
    endfunction

    function automatic bit tree_query(input int node, input int lo, input int hi,
                                      input int ql, input int qr, output longint res);
        int     mid;
        longint a;
        longint b;
        bit     ha;
        bit     hb;
        a = 0;
        b = 0;
        res = 0;
        settle_node(node, lo, hi);
        if (lo > qr || hi < ql) return 1'b0;
        if (lo >= ql && hi <= qr) begin
            res = tree_max_q[node];
            return 1'b1;
        end
        mid = (lo + hi) >> 1;
        ha = tree_query(2*node, lo, mid, ql, qr, a);
        hb = tree_query(2*node+1, mid + 1, hi, ql, qr, b);
        if (ha && hb) res = (a > b) ? a : b;
        else if (ha) res = a;
        else if (hb) res = b;
        return ha || hb;
    endfunction

    // Brings the model up to date with one accepted request and returns
    // whether it produces a response, and which.
    function automatic bit predict_beat(input rart_pkg::t_req r, output rart_pkg::t_rsp rsp);
        longint best;
        bit     found;
        int     ql;
        int     qr;
        ql = r.range_low;
        qr = r.range_high;
        best = 0;
        found = 1'b0;
        rsp = '0;
        if (r.opcode == rart_pkg::OP_ADD) begin
            if (ql <= qr && ql < N_ELEM)
                tree_add(1, 0, N_ELEM - 1, ql, qr, longint'(r.add_amount));
            return 1'b0;
        end
        if (ql <= qr && ql < N_ELEM)
            found = tree_query(1, 0, N_ELEM - 1, ql, qr, best);
        if (!found) best = 0;
        rsp.range_maximum = best[rart_pkg::RESULT_BITS-1:0];
        rsp.range_empty   = !found;
        return 1'b1;
    endfunction

    // Presents one request beat and holds it until the block takes it. The
    // model is updated at the very edge of acceptance.
    task automatic send_beat(input rart_pkg::t_req r, input bit has_exp,
                             input rart_pkg::t_rsp typed);
        rart_pkg::t_rsp pred;
        bit             gives;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        gives = predict_beat(r, pred);
        if (gives) pending_rsp_q.push_back(has_exp ? typed : pred);
    endtask

    task automatic maybe_gap();
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 9);
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic int pick_index();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return N_ELEM - 1;
            2: return $urandom_range(0, 15);
            3: return $urandom_range(N_ELEM - 16, N_ELEM - 1);
            default: return $urandom_range(0, N_ELEM - 1);
        endcase
    endfunction

    function automatic int pick_amount();
        case ($urandom_range(0, 4))
            0: return int'($urandom());
            1: return $urandom_range(0, 2000) - 1000;
            2: return 32'h7fffffff;
            3: return 32'h80000000;
            default: return int'($urandom()) >>> $urandom_range(0, 31);
        endcase
    endfunction

    // Source side: the directed table first, then random beats. Ranges are
    // mostly well formed; a few are reversed so the no-op path is hit too.
    initial begin
        t_dir_row       rows[21];
        rart_pkg::t_req r;
        rart_pkg::t_rsp typed;
        int             lo;
        int             hi;
        int             t;
        quiet = 1'b0;
        stim_done = 1'b0;
        err_count = 0;
        for (int k = 0; k < 2*N_ELEM; k++) begin
            tree_max_q[k]  = 0;
            tree_pend_q[k] = 0;
        end
        req_if.valid = 1'b0;
        req_if.data  = '0;

        rows[0]  = '{rart_pkg::OP_QUERY, 0,    1023, 0,            1, 0,             0};
        rows[1]  = '{rart_pkg::OP_QUERY, 10,   3,    0,            1, 0,             1};
        // A query ignores whatever amount rides along with it.
        rows[2]  = '{rart_pkg::OP_QUERY, 1023, 1023, 32'h7fffffff, 1, 0,             0};
        rows[3]  = '{rart_pkg::OP_ADD,   0,    1023, 32'h7fffffff, 0, 0,             0};
        rows[4]  = '{rart_pkg::OP_QUERY, 0,    1023, 0,            1, 2147483647,    0};
        rows[5]  = '{rart_pkg::OP_ADD,   0,    0,    32'h80000000, 0, 0,             0};
        rows[6]  = '{rart_pkg::OP_QUERY, 0,    0,    0,            1, -1,            0};
        rows[7]  = '{rart_pkg::OP_QUERY, 1,    1023, 0,            1, 2147483647,    0};
        // A reversed add leaves every element as it was.
        rows[8]  = '{rart_pkg::OP_ADD,   600,  500,  12345,        0, 0,             0};
        rows[9]  = '{rart_pkg::OP_QUERY, 0,    1023, 0,            1, 2147483647,    0};
        rows[10] = '{rart_pkg::OP_ADD,   1023, 1023, 32'h7fffffff, 0, 0,             0};
        rows[11] = '{rart_pkg::OP_QUERY, 1023, 1023, 0,            1, 64'sd4294967294, 0};
        rows[12] = '{rart_pkg::OP_QUERY, 1023, 0,    32'hffffffff, 1, 0,             1};
        rows[13] = '{rart_pkg::OP_ADD,   512,  512,  -5,           0, 0,             0};
        rows[14] = '{rart_pkg::OP_QUERY, 511,  512,  0,            1, 2147483647,    0};
        rows[15] = '{rart_pkg::OP_ADD,   1,    1022, 32'h80000000, 0, 0,             0};
        rows[16] = '{rart_pkg::OP_QUERY, 1,    1022, 0,            1, -1,            0};
        rows[17] = '{rart_pkg::OP_QUERY, 0,    1023, 0,            1, 64'sd4294967294, 0};
        rows[18] = '{rart_pkg::OP_QUERY, 512,  512,  0,            1, -6,            0};
        rows[19] = '{rart_pkg::OP_ADD,   0,    1023, 0,            0, 0,             0};
        rows[20] = '{rart_pkg::OP_QUERY, 300,  700,  0,            0, 0,             0};

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        foreach (rows[k]) begin
            r.opcode     = rows[k].op;
            r.range_low  = rows[k].lo[rart_pkg::INDEX_BITS-1:0];
            r.range_high = rows[k].hi[rart_pkg::INDEX_BITS-1:0];
            r.add_amount = rows[k].amt;
            typed.range_maximum = rows[k].exp_max[rart_pkg::RESULT_BITS-1:0];
            typed.range_empty   = rows[k].exp_empty;
            send_beat(r, rows[k].has_exp, typed);
            maybe_gap();
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == QUIET_AFTER) quiet = 1'b1;
            lo = pick_index();
            hi = pick_index();
            t = $urandom_range(0, 9);
            if (t == 0) begin
                // Leave the pair as drawn, reversed or not, to mix in noise.
            end else if (t == 1) begin
                hi = lo;
            end else if (t == 2) begin
                lo = 0;
                hi = N_ELEM - 1;
            end else if (lo > hi) begin
                {lo, hi} = {hi, lo};
            end
            r.opcode     = ($urandom_range(0, 1) == 0) ? rart_pkg::OP_ADD : rart_pkg::OP_QUERY;
            r.range_low  = lo[rart_pkg::INDEX_BITS-1:0];
            r.range_high = hi[rart_pkg::INDEX_BITS-1:0];
            r.add_amount = pick_amount();
            send_beat(r, 1'b0, '0);
            maybe_gap();
        end
        req_if.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Sink side: ready drops in random bursts until the quiet stretch.
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 8);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Every response beat is held against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        rart_pkg::t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp_q.size() == 0) begin
                report_mismatch("response beat with nothing expected");
            end else begin
                want = pending_rsp_q.pop_front();
                if (rsp_if.data.range_maximum !== want.range_maximum)
                    report_mismatch($sformatf("range_maximum %0d, expected %0d",
                        rsp_if.data.range_maximum, want.range_maximum));
                if (rsp_if.data.range_empty !== want.range_empty)
                    report_mismatch($sformatf("range_empty %0b, expected %0b",
                        rsp_if.data.range_empty, want.range_empty));
            end
        end
    end

    // Drain: wait for the last response, then a margin for any stray beat.
    initial begin
        @(posedge i_clk);
        while (!stim_done || pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run, clearing sweep included.
    initial begin
        #50000000;
        $display("timeout waiting for the block");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/rart_pkg.sv
rtl/rart_chan.sv
rtl/rart_ram.sv
rtl/range_add_range_max_tree.sv
bench/tb_range_add_range_max_tree.sv
